// File: sv/ttl_pkg.sv
// shared types, constants and character classes of the text token lexer
package ttl_pkg;

   localparam int CFG_W  = 11;
   localparam int LINE_W = 20;

   localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;
   localparam logic [LINE_W-1:0] LINE_TOP  = 20'hFFFFF;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDLE_CMT,
      MODE_INT,
      MODE_IDENT,
      MODE_STR,
      MODE_STR_ESC,
      MODE_POST,
      MODE_POST_CMT,
      MODE_DROP_TO_Q,
      MODE_DROP_THRU_Q
   } lex_mode_type;

   localparam logic [2:0] TOK_OP    = 3'd0;
   localparam logic [2:0] TOK_STR   = 3'd1;
   localparam logic [2:0] TOK_INT   = 3'd2;
   localparam logic [2:0] TOK_IDENT = 3'd3;
   localparam logic [2:0] TOK_ERR   = 3'd4;
   localparam logic [2:0] TOK_LONG  = 3'd5;
   localparam logic [2:0] TOK_END   = 3'd6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LC_N  = 8'h6E;

   // lexer state other than the stored character count
   typedef struct packed {
      lex_mode_type      mode;
      logic              combine;
      logic              slash;
      logic [LINE_W-1:0] line;
   } lex_state_type;

   typedef struct packed {
      logic [7:0]        ch;
      logic              char_valid;
      logic              token_done;
      logic [2:0]        token_type;
      logic [LINE_W-1:0] line;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NUL);
   endfunction

   // @ , ! + & * $ . = : [ ] ( ) { } and backslash
   function automatic logic is_op(input logic [7:0] b);
      return b inside {8'h40, 8'h2C, 8'h21, 8'h2B, 8'h26, 8'h2A, 8'h24, 8'h2E, 8'h3D,
                       8'h3A, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5C};
   endfunction

   function automatic logic [LINE_W-1:0] bump(input logic [LINE_W-1:0] l);
      return (l != LINE_TOP) ? l + LINE_W'(1) : l;
   endfunction

   function automatic result_type mk_char(input logic [7:0] c, input logic [LINE_W-1:0] l);
      return '{ch: c, char_valid: 1'b1, token_done: 1'b0, token_type: TOK_OP, line: l};
   endfunction

   function automatic result_type mk_done(input logic [2:0] t, input logic [LINE_W-1:0] l);
      return '{ch: 8'h00, char_valid: 1'b0, token_done: 1'b1, token_type: t, line: l};
   endfunction

endpackage

// File: sv/ttl_step.sv
// next-state and result logic for one input beat of the lexer
module ttl_step
   import ttl_pkg::*;
#(
   parameter int MAX_TOKEN = 1024
) (
   input  lex_state_type                    cur,
   input  logic [((MAX_TOKEN > 2048) ? 11 : $clog2(MAX_TOKEN))-1:0] cur_count,
   input  logic [7:0]                       in_byte,
   input  logic                             end_of_input,
   input  logic [CFG_W-1:0]                 max_len,
   output lex_state_type                    nxt,
   output logic [((MAX_TOKEN > 2048) ? 11 : $clog2(MAX_TOKEN))-1:0] nxt_count,
   output result_type [2:0]                 results,
   output logic [1:0]                       res_count
);

   localparam int CNT_W = (MAX_TOKEN > 2048) ? 11 : $clog2(MAX_TOKEN);
   localparam int CAP_W = CNT_W + 1;

   logic [CAP_W-1:0]  cap;
   lex_mode_type      mode;
   logic [CNT_W-1:0]  cnt;
   logic              comb;
   logic              slash;
   logic [LINE_W-1:0] line;
   logic [1:0]        n;
   logic              do_skip;
   logic              post_ctx;
   lex_mode_type      skip_cmt;
   logic              starts;
   logic              hit_slash;
   logic [7:0]        b;

   always_comb begin
      if (32'(max_len) > MAX_TOKEN) begin
         cap = CAP_W'(MAX_TOKEN);
      end else begin
         cap = CAP_W'(max_len);
      end
   end

   always_comb begin
      b         = in_byte;
      mode      = cur.mode;
      cnt       = cur_count;
      comb      = cur.combine;
      slash     = cur.slash;
      line      = cur.line;
      n         = 2'd0;
      results   = '0;
      do_skip   = 1'b0;
      post_ctx  = 1'b0;
      skip_cmt  = MODE_IDLE_CMT;
      starts    = 1'b0;
      hit_slash = 1'b0;

      if (end_of_input) begin
         case (mode)
            MODE_IDLE_CMT: line = bump(line);
            MODE_INT: begin
               results[n] = mk_done(TOK_INT, line);
               n = n + 2'd1;
            end
            MODE_IDENT: begin
               results[n] = mk_done(TOK_IDENT, line);
               n = n + 2'd1;
            end
            MODE_POST: begin
               results[n] = mk_done(TOK_STR, line);
               n = n + 2'd1;
            end
            MODE_POST_CMT: begin
               line = bump(line);
               results[n] = mk_done(TOK_STR, line);
               n = n + 2'd1;
            end
            default: ;
         endcase
         mode  = MODE_IDLE;
         slash = 1'b0;
         results[n] = mk_done(TOK_END, line);
         n = n + 2'd1;
      end else begin
         case (mode)
            MODE_IDLE_CMT, MODE_POST_CMT: begin
               if (b == CH_LF) begin
                  line = bump(line);
                  mode = (mode == MODE_IDLE_CMT) ? MODE_IDLE : MODE_POST;
               end
            end
            MODE_INT: begin
               if (is_digit(b)) begin
                  if (({1'b0, cnt} + CAP_W'(1)) < cap) begin
                     results[n] = mk_char(b, line);
                     n = n + 2'd1;
                     cnt = cnt + CNT_W'(1);
                  end
               end else if (b == CH_MINUS || is_alpha(b) || b == CH_UNDER) begin
                  results[n] = mk_done(TOK_ERR, line);
                  n = n + 2'd1;
                  mode = MODE_IDLE;
               end else begin
                  results[n] = mk_done(TOK_INT, line);
                  n = n + 2'd1;
                  do_skip = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
                  if (({1'b0, cnt} + CAP_W'(1)) < cap) begin
                     results[n] = mk_char(b, line);
                     n = n + 2'd1;
                     cnt = cnt + CNT_W'(1);
                  end
               end else begin
                  results[n] = mk_done(TOK_IDENT, line);
                  n = n + 2'd1;
                  do_skip = 1'b1;
               end
            end
            MODE_STR: begin
               if (b == CH_QUOTE) begin
                  mode  = MODE_POST;
                  comb  = 1'b0;
                  slash = 1'b0;
               end else if (!(({1'b0, cnt} + CAP_W'(1)) < cap)) begin
                  results[n] = mk_done(TOK_LONG, line);
                  n = n + 2'd1;
                  mode = MODE_DROP_THRU_Q;
               end else if (b == CH_CR) begin
                  results[n] = mk_done(TOK_LONG, line);
                  n = n + 2'd1;
                  mode = MODE_DROP_TO_Q;
               end else if (b == CH_BSL) begin
                  mode = MODE_STR_ESC;
               end else begin
                  results[n] = mk_char(b, line);
                  n = n + 2'd1;
                  cnt = cnt + CNT_W'(1);
               end
            end
            MODE_STR_ESC: begin
               results[n] = mk_char((b == CH_LC_N) ? CH_LF : b, line);
               n = n + 2'd1;
               cnt = cnt + CNT_W'(1);
               mode = MODE_STR;
            end
            MODE_POST: begin
               do_skip  = 1'b1;
               post_ctx = 1'b1;
               skip_cmt = MODE_POST_CMT;
            end
            MODE_DROP_TO_Q: begin
               if (b == CH_QUOTE) begin
                  do_skip = 1'b1;
               end
            end
            MODE_DROP_THRU_Q: begin
               if (b == CH_QUOTE) begin
                  mode = MODE_IDLE;
               end
            end
            default: do_skip = 1'b1;
         endcase

         if (do_skip && !post_ctx) begin
            mode = MODE_IDLE;
         end

         // white space, plus signs, newlines and comment openers
         if (do_skip) begin
            if (slash) begin
               slash = 1'b0;
               if (b == CH_SLASH) begin
                  mode      = skip_cmt;
                  hit_slash = 1'b1;
               end
            end
            if (!hit_slash) begin
               if (b == CH_PLUS) begin
                  comb = 1'b1;
               end else if (b == CH_LF) begin
                  line = bump(line);
               end else if (b == CH_SLASH) begin
                  slash = 1'b1;
               end else if (!is_blank(b)) begin
                  starts = 1'b1;
               end
            end
         end

         if (starts) begin
            if (post_ctx && b == CH_QUOTE && comb) begin
               comb = 1'b0;
               mode = MODE_STR;
            end else begin
               if (post_ctx) begin
                  results[n] = mk_done(TOK_STR, line);
                  n = n + 2'd1;
               end
               mode = MODE_IDLE;
               cnt  = '0;
               if (is_op(b)) begin
                  results[n] = mk_char(b, line);
                  n = n + 2'd1;
                  results[n] = mk_done(TOK_OP, line);
                  n = n + 2'd1;
               end else if (b == CH_QUOTE) begin
                  if (cap == '0) begin
                     results[n] = mk_done(TOK_ERR, line);
                     n = n + 2'd1;
                  end else begin
                     mode = MODE_STR;
                  end
               end else if (is_digit(b) || b == CH_MINUS ||
                            is_alpha(b) || b == CH_UNDER) begin
                  mode = (is_digit(b) || b == CH_MINUS) ? MODE_INT : MODE_IDENT;
                  if (CAP_W'(1) < cap) begin
                     results[n] = mk_char(b, line);
                     n = n + 2'd1;
                     cnt = CNT_W'(1);
                  end
               end else begin
                  // stray byte gives an empty identifier
                  results[n] = mk_done(TOK_IDENT, line);
                  n = n + 2'd1;
               end
            end
         end
      end

      nxt.mode    = mode;
      nxt.combine = comb;
      nxt.slash   = slash;
      nxt.line    = line;
      nxt_count   = cnt;
      res_count   = n;
   end

endmodule

// File: sv/text_token_lexer_core.sv
// an accepted byte's results are registered into the result buffer and offered from slot 0
// throughput: one byte per cycle while rsp_ready is high and bytes yield at most one result
//   each; a byte that yields two or three results is drained one per cycle from a result
//   buffer of four entries, and req_ready drops while more than one entry would remain
// reset (synchronous, active high): idle between tokens, line 1, max length 1024,
//   result buffer empty
module text_token_lexer_core
   import ttl_pkg::*;
#(
   parameter int MAX_TOKEN = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_input,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_char_valid,
   output logic              rsp_token_done,
   output logic [2:0]        rsp_token_type,
   output logic [LINE_W-1:0] rsp_line_number
);

   localparam int CNT_W = (MAX_TOKEN > 2048) ? 11 : $clog2(MAX_TOKEN);

   logic [CFG_W-1:0] max_len_ff;
   lex_state_type    state_ff;
   lex_state_type    state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   result_type [3:0] slot_ff;
   result_type [3:0] slot_in;
   logic [2:0]       fill_ff;
   logic [2:0]       fill_in;
   result_type [2:0] results;
   logic [1:0]       res_count;
   logic             pop;
   logic             acc;
   logic [2:0]       base;
   logic [2:0]       idx;

   ttl_step #(
      .MAX_TOKEN (MAX_TOKEN)
   ) u_step (
      .cur          (state_ff),
      .cur_count    (count_ff),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .max_len      (max_len_ff),
      .nxt          (state_in),
      .nxt_count    (count_in),
      .results      (results),
      .res_count    (res_count)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = (fill_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign base      = fill_ff - {2'b00, pop};
   assign req_ready = (base <= 3'd1);
   assign acc       = req_valid && req_ready;

   assign rsp_out_char    = slot_ff[0].ch;
   assign rsp_char_valid  = slot_ff[0].char_valid;
   assign rsp_token_done  = slot_ff[0].token_done;
   assign rsp_token_type  = slot_ff[0].token_type;
   assign rsp_line_number = slot_ff[0].line;

   // result buffer shifts toward slot 0 on each taken beat, new results land behind
   always_comb begin
      idx = 3'd0;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         slot_in[2] = slot_ff[3];
         slot_in[3] = slot_ff[3];
      end else begin
         slot_in = slot_ff;
      end
      for (int j = 0; j < 4; j++) begin
         idx = 3'(j) - base;
         if (acc && (3'(j) >= base) && (idx < {1'b0, res_count})) begin
            slot_in[j] = results[idx[1:0]];
         end
      end
      fill_in = base + (acc ? {1'b0, res_count} : 3'd0);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         max_len_ff <= CFG_RESET;
         state_ff   <= '{mode: MODE_IDLE, combine: 1'b0, slash: 1'b0, line: LINE_W'(1)};
         count_ff   <= '0;
         fill_ff    <= 3'd0;
      end else begin
         fill_ff <= fill_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
         if (acc) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 3'd4)
      else $error("result buffer overfilled");

   a_beat_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_valid != rsp_token_done))
      else $error("result beat is neither a character nor a token end");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0))
      else $error("line number zero");

   a_line_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (state_ff.line >= $past(state_ff.line)))
      else $error("line count went backward");

endmodule
